// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL files; lattice_gas_node_collision includes them.
// Every check is clocked on i_clk and is switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold in every cycle.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lgnc_pkg.sv =====
`default_nettype none

package lgnc_pkg;

    localparam int DEF_COUNT_WIDTH = 12;
    localparam int VEL             = 9;
    localparam int SLOT_W          = 4;
    localparam int DRAW_W          = 31;
    localparam int STEP_W          = 5;
    localparam logic [DRAW_W-1:0] RATE_RESET = 31'd268435455;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_COLLIDE = 2'd1,
        ACT_READ    = 2'd2
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_MOD1,
        S_MOD2,
        S_WALK1,
        S_WALK2,
        S_COLLIDE,
        S_DEC1,
        S_DEC2,
        S_INC1,
        S_INC2,
        S_RESULT
    } t_state;

    // Command to the count file: one address serves both read and write.
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
    } t_cf_cmd;

    // Velocity components are held offset by one: 0 is -1, 1 is 0, 2 is +1.
    typedef struct packed {
        logic [1:0] x;
        logic [1:0] y;
    } t_coord;

    typedef struct packed {
        logic [1:0] a;
        logic [1:0] b;
    } t_pair;

    function automatic t_coord slot_coord(input logic [SLOT_W-1:0] v);
        t_coord c;
        unique case (v)
            4'd0:    c = '{x: 2'd0, y: 2'd0};
            4'd1:    c = '{x: 2'd1, y: 2'd0};
            4'd2:    c = '{x: 2'd2, y: 2'd0};
            4'd3:    c = '{x: 2'd0, y: 2'd1};
            4'd4:    c = '{x: 2'd1, y: 2'd1};
            4'd5:    c = '{x: 2'd2, y: 2'd1};
            4'd6:    c = '{x: 2'd0, y: 2'd2};
            4'd7:    c = '{x: 2'd1, y: 2'd2};
            4'd8:    c = '{x: 2'd2, y: 2'd2};
            default: c = '{x: 2'd1, y: 2'd1};
        endcase
        return c;
    endfunction

    function automatic logic [SLOT_W-1:0] coord_slot(input t_coord c);
        return SLOT_W'(c.y) * SLOT_W'(3) + SLOT_W'(c.x);
    endfunction

    // Collision rule on one axis: cancel opposite components, excite a
    // resting pair when the draw falls below the threshold, otherwise swap.
    function automatic t_pair collide_axis(input logic [1:0] a, input logic [1:0] b,
                                           input logic [DRAW_W-1:0] draw,
                                           input logic [DRAW_W-1:0] rate);
        t_pair p;
        if ((a == 2'd0 && b == 2'd2) || (a == 2'd2 && b == 2'd0)) begin
            p = '{a: 2'd1, b: 2'd1};
        end else if (a == 2'd1 && b == 2'd1) begin
            if (draw < rate) begin
                if (draw < (rate >> 1)) begin
                    p = '{a: 2'd0, b: 2'd2};
                end else begin
                    p = '{a: 2'd2, b: 2'd0};
                end
            end else begin
                p = '{a: a, b: b};
            end
        end else begin
            p = '{a: b, b: a};
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== sv/lattice_gas_node_collision.sv =====
`default_nettype none

// Particle store of one node of a nine-velocity lattice gas.
// An item is taken at a clock edge where start is high and busy is low; the
// payload ports are sampled at that edge. busy stays high until the result
// beat, which is shown for exactly one cycle with o_done high. The receiver
// cannot stall, so the beat is simply gone after that cycle.
// A load writes its count first; a read (or the unused action code) and a
// collision attempt on an empty node go straight to the result. Otherwise
// it runs two 31-step restoring remainder reductions (ending there if both
// draws give the same remainder) and two walks of up to nine counts, all on
// the one shared compare/subtract unit, then four count updates through the
// single port of the count file. busy drops in the cycle of the result beat,
// so the next item may be taken at the edge that ends it. rate_threshold is
// to be written through i_cfg_we/i_cfg_wdata while the block is idle, which
// it does not enforce. Synchronous reset clears all nine counts, loads the
// threshold default, and leaves the block idle with no beat pending.
module lattice_gas_node_collision
    import lgnc_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        i_action,
    input  wire logic [3:0]        i_vel_index,
    input  wire logic [11:0]       i_load_value,
    input  wire logic [DRAW_W-1:0] i_draw_first,
    input  wire logic [DRAW_W-1:0] i_draw_second,
    input  wire logic [DRAW_W-1:0] i_draw_x,
    input  wire logic [DRAW_W-1:0] i_draw_y,
    input  wire logic              i_cfg_we,
    input  wire logic [DRAW_W-1:0] i_cfg_wdata,
    output logic                   o_done,
    output logic [11:0]            o_count_value,
    output logic [15:0]            o_total_count,
    output logic                   o_collided,
    output logic [3:0]             o_picked_first,
    output logic [3:0]             o_picked_second
);

`include "assert_macros.svh"

    localparam int TOT_W = COUNT_WIDTH + 4;
    localparam int SUB_W = TOT_W + 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [STEP_W-1:0]      LAST_STEP = STEP_W'(DRAW_W - 1);

    t_state r_state, n_state;

    logic [DRAW_W-1:0]      r_rate;
    logic [SLOT_W-1:0]      r_idx;
    logic [11:0]            r_load;
    logic [DRAW_W-1:0]      r_shift;
    logic [DRAW_W-1:0]      r_d2;
    logic [DRAW_W-1:0]      r_dx;
    logic [DRAW_W-1:0]      r_dy;
    logic [STEP_W-1:0]      r_step;
    logic [TOT_W-1:0]       r_rem;
    logic [TOT_W-1:0]       r_r1;
    logic [TOT_W-1:0]       r_r2;
    logic [SLOT_W-1:0]      r_walk;
    logic [SLOT_W-1:0]      r_v1;
    logic [SLOT_W-1:0]      r_v2;
    logic [SLOT_W-1:0]      r_n1;
    logic [SLOT_W-1:0]      r_n2;
    logic                   r_moved;
    logic                   r_sat;

    logic                   accept;
    t_cf_cmd                cf_cmd;
    logic [COUNT_WIDTH-1:0] cf_wdata;
    logic [COUNT_WIDTH-1:0] cf_rdata;
    logic [TOT_W-1:0]       total;
    logic [SUB_W-1:0]       sub_a;
    logic [SUB_W-1:0]       sub_b;
    logic                   sub_ge;
    logic [SUB_W-1:0]       sub_diff;
    logic [TOT_W-1:0]       rem_step;
    logic                   walk_found;
    logic                   at_max;
    logic [COUNT_WIDTH+11:0] count_ext;
    logic [TOT_W+15:0]      total_ext;
    logic [COUNT_WIDTH+11:0] load_ext;
    t_coord                 c1;
    t_coord                 c2;
    t_pair                  px;
    t_pair                  py;
    logic [SLOT_W-1:0]      new1;
    logic [SLOT_W-1:0]      new2;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    lgnc_count_file #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_count_file (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cf_cmd),
        .i_wdata(cf_wdata),
        .o_rdata(cf_rdata),
        .o_total(total)
    );

    lgnc_sub_unit #(
        .W(SUB_W)
    ) u_sub_unit (
        .i_a   (sub_a),
        .i_b   (sub_b),
        .o_ge  (sub_ge),
        .o_diff(sub_diff)
    );

    // In the remainder steps the subtrahend is the node total; in the walks
    // it is the count at the walk position.
    always_comb begin
        if (r_state == S_MOD1 || r_state == S_MOD2) begin
            sub_a = {r_rem, r_shift[DRAW_W-1]};
            sub_b = {1'b0, total};
        end else begin
            sub_a = {1'b0, r_rem};
            sub_b = {5'b0, cf_rdata};
        end
    end

    assign rem_step   = sub_ge ? sub_diff[TOT_W-1:0] : sub_a[TOT_W-1:0];
    assign walk_found = (r_walk == SLOT_W'(VEL - 1)) || !sub_ge;
    assign at_max     = (cf_rdata == COUNT_MAX);
    assign load_ext   = {{COUNT_WIDTH{1'b0}}, r_load};

    // New velocities of the two picked particles.
    always_comb begin
        c1   = slot_coord(r_v1);
        c2   = slot_coord(r_v2);
        px   = collide_axis(c1.x, c2.x, r_dx, r_rate);
        py   = collide_axis(c1.y, c2.y, r_dy, r_rate);
        new1 = coord_slot('{x: px.a, y: py.a});
        new2 = coord_slot('{x: px.b, y: py.b});
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_action)
                        ACT_LOAD:    n_state = S_LOAD;
                        ACT_COLLIDE: n_state = (total == '0) ? S_RESULT : S_MOD1;
                        default:     n_state = S_RESULT;
                    endcase
                end
            end
            S_LOAD:    n_state = S_RESULT;
            S_MOD1:    n_state = (r_step == '0) ? S_MOD2 : S_MOD1;
            S_MOD2: begin
                if (r_step == '0) begin
                    n_state = (rem_step == r_r1) ? S_RESULT : S_WALK1;
                end
            end
            S_WALK1:   n_state = walk_found ? S_WALK2 : S_WALK1;
            S_WALK2:   n_state = walk_found ? S_COLLIDE : S_WALK2;
            S_COLLIDE: n_state = S_DEC1;
            S_DEC1:    n_state = S_DEC2;
            S_DEC2:    n_state = S_INC1;
            S_INC1:    n_state = S_INC2;
            S_INC2:    n_state = S_RESULT;
            S_RESULT:  n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Count file port: address, write enable and write data per state.
    always_comb begin
        cf_cmd   = '{we: 1'b0, addr: r_idx};
        cf_wdata = cf_rdata;
        unique case (r_state)
            S_LOAD: begin
                cf_cmd   = '{we: (r_idx < SLOT_W'(VEL)), addr: r_idx};
                cf_wdata = load_ext[COUNT_WIDTH-1:0];
            end
            S_WALK1, S_WALK2: cf_cmd = '{we: 1'b0, addr: r_walk};
            S_DEC1: begin
                cf_cmd   = '{we: 1'b1, addr: r_v1};
                cf_wdata = cf_rdata - COUNT_WIDTH'(1);
            end
            S_DEC2: begin
                cf_cmd   = '{we: 1'b1, addr: r_v2};
                cf_wdata = cf_rdata - COUNT_WIDTH'(1);
            end
            S_INC1: begin
                cf_cmd   = '{we: 1'b1, addr: r_n1};
                cf_wdata = at_max ? cf_rdata : cf_rdata + COUNT_WIDTH'(1);
            end
            S_INC2: begin
                cf_cmd   = '{we: 1'b1, addr: r_n2};
                cf_wdata = at_max ? cf_rdata : cf_rdata + COUNT_WIDTH'(1);
            end
            default: cf_cmd = '{we: 1'b0, addr: r_idx};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rate  <= RATE_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_rate <= i_cfg_wdata;
            end
        end
    end

    // Item payload and work registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx   <= i_vel_index;
            r_load  <= i_load_value;
            r_shift <= i_draw_first;
            r_d2    <= i_draw_second;
            r_dx    <= i_draw_x;
            r_dy    <= i_draw_y;
            r_rem   <= '0;
            r_step  <= LAST_STEP;
            r_v1    <= '0;
            r_v2    <= '0;
            r_moved <= 1'b0;
            r_sat   <= 1'b0;
        end else begin
            unique case (r_state)
                S_MOD1: begin
                    if (r_step == '0) begin
                        r_r1    <= rem_step;
                        r_rem   <= '0;
                        r_shift <= r_d2;
                        r_step  <= LAST_STEP;
                    end else begin
                        r_rem   <= rem_step;
                        r_shift <= r_shift << 1;
                        r_step  <= r_step - STEP_W'(1);
                    end
                end
                S_MOD2: begin
                    if (r_step == '0) begin
                        r_r2   <= rem_step;
                        r_rem  <= r_r1;
                        r_walk <= '0;
                    end else begin
                        r_rem   <= rem_step;
                        r_shift <= r_shift << 1;
                        r_step  <= r_step - STEP_W'(1);
                    end
                end
                S_WALK1: begin
                    if (walk_found) begin
                        r_v1   <= r_walk;
                        r_rem  <= r_r2;
                        r_walk <= '0;
                    end else begin
                        r_rem  <= sub_diff[TOT_W-1:0];
                        r_walk <= r_walk + SLOT_W'(1);
                    end
                end
                S_WALK2: begin
                    if (walk_found) begin
                        r_v2 <= r_walk;
                    end else begin
                        r_rem  <= sub_diff[TOT_W-1:0];
                        r_walk <= r_walk + SLOT_W'(1);
                    end
                end
                S_COLLIDE: begin
                    r_n1 <= new1;
                    r_n2 <= new2;
                    // Counts change unless the pair lands back on the same slots.
                    r_moved <= !((new1 == r_v1 && new2 == r_v2) ||
                                 (new1 == r_v2 && new2 == r_v1));
                end
                S_INC1, S_INC2: begin
                    if (at_max) begin
                        r_sat <= 1'b1;
                    end
                end
                default: begin
                    r_step <= r_step;
                end
            endcase
        end
    end

    assign count_ext = {12'b0, cf_rdata};
    assign total_ext = {16'b0, total};

    // Result beat, registered so that it lasts exactly one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= (r_state == S_RESULT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RESULT) begin
            o_count_value   <= count_ext[11:0];
            o_total_count   <= total_ext[15:0];
            o_collided      <= r_moved || r_sat;
            o_picked_first  <= r_v1;
            o_picked_second <= r_v2;
        end
    end

    `ASSERT_IMPL(a_done_idle, o_done, !busy, "result beat while still busy")
    `ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item did not raise busy")
    `ASSERT_IMPL(a_walk_range, r_state == S_WALK1 || r_state == S_WALK2,
                 r_walk < SLOT_W'(VEL), "walk ran past the last slot")
    `ASSERT_IMPL(a_write_range, cf_cmd.we, cf_cmd.addr < SLOT_W'(VEL),
                 "count write outside the nine slots")

endmodule

`default_nettype wire

// ===== sv/lgnc_sub_unit.sv =====
`default_nettype none

// Shared compare and subtract: o_diff is valid as a result when o_ge is set.
module lgnc_sub_unit
    import lgnc_pkg::*;
#(
    parameter int W = DEF_COUNT_WIDTH + 5
) (
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output logic              o_ge,
    output logic [W-1:0]      o_diff
);

    logic [W:0] wide;

    assign wide   = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~wide[W];
    assign o_diff = wide[W-1:0];

endmodule

`default_nettype wire

// ===== sv/lgnc_count_file.sv =====
`default_nettype none

// Nine particle counts with one read/write address and a running total.
module lgnc_count_file
    import lgnc_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cf_cmd                i_cmd,
    input  wire logic [COUNT_WIDTH-1:0] i_wdata,
    output logic [COUNT_WIDTH-1:0]      o_rdata,
    output logic [COUNT_WIDTH+3:0]      o_total
);

    localparam int TOT_W = COUNT_WIDTH + 4;

    logic [COUNT_WIDTH-1:0] r_cnt [VEL];
    logic [TOT_W-1:0]       r_total;
    logic                   in_range;

    assign in_range = (i_cmd.addr < SLOT_W'(VEL));
    assign o_rdata  = in_range ? r_cnt[i_cmd.addr] : '0;
    assign o_total  = r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VEL; i++) begin
                r_cnt[i] <= '0;
            end
            r_total <= '0;
        end else if (i_cmd.we && in_range) begin
            r_cnt[i_cmd.addr] <= i_wdata;
            r_total <= r_total - TOT_W'(o_rdata) + TOT_W'(i_wdata);
        end
    end

endmodule

`default_nettype wire
